// ----- design/hsr_pkg.sv -----
// Shared constants and types for the stereo cubic Hermite resampler.
package hsr_pkg;

    // Extra bits above the sample width for Horner coefficients and partial sums
    localparam int ACC_GUARD_BITS = 6;

    // Fill status of the job queue between front and back end
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- design/hsr_job_queue.sv -----
// Two-entry job queue that decouples the phase front end from the interpolation back end.
module hsr_job_queue #(
    parameter int WIDTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [WIDTH-1:0]  i_data,
    input  logic              i_pop,
    output logic [WIDTH-1:0]  o_data,
    output hsr_pkg::t_q_status o_status
);

    logic             r_v0;
    logic             r_v1;
    logic [WIDTH-1:0] r_d0;
    logic [WIDTH-1:0] r_d1;

    // head entry sits in slot 0, a second job waits in slot 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (i_pop && i_push) begin
            if (r_v1) begin
                r_d0 <= r_d1;
                r_d1 <= i_data;
            end else begin
                r_d0 <= i_data;
            end
        end else if (i_pop) begin
            r_d0 <= r_d1;
            r_v0 <= r_v1;
            r_v1 <= 1'b0;
        end else if (i_push) begin
            if (!r_v0) begin
                r_d0 <= i_data;
                r_v0 <= 1'b1;
            end else begin
                r_d1 <= i_data;
                r_v1 <= 1'b1;
            end
        end
    end

    assign o_data         = r_d0;
    assign o_status.full  = r_v1;
    assign o_status.empty = !r_v0;

endmodule

// ----- design/hsr_front.sv -----
// Front end: history shift, Hermite coefficients and read-phase stepping into output jobs.
module hsr_front #(
    parameter int SAMPLE_BITS           = 24,
    parameter int PHASE_FRAC_BITS       = 16,
    parameter int MAX_OUTPUTS_PER_INPUT = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_left,
    input  logic signed [SAMPLE_BITS-1:0] i_right,
    input  logic [PHASE_FRAC_BITS+1:0]  i_step,
    input  hsr_pkg::t_q_status          i_q_status,
    output logic                        o_push,
    output logic [8*(SAMPLE_BITS+hsr_pkg::ACC_GUARD_BITS)+PHASE_FRAC_BITS:0] o_job
);

    localparam int AW = SAMPLE_BITS + hsr_pkg::ACC_GUARD_BITS;
    localparam int PW = PHASE_FRAC_BITS + 3;
    localparam int CW = $clog2(MAX_OUTPUTS_PER_INPUT + 1);
    localparam logic [PW-1:0] PH_ONE = PW'(1) << PHASE_FRAC_BITS;

    typedef enum logic {
        F_IDLE,
        F_GEN
    } t_fstate;

    t_fstate r_state;
    logic signed [SAMPLE_BITS-1:0] r_hl [4];
    logic signed [SAMPLE_BITS-1:0] r_hr [4];
    logic [PHASE_FRAC_BITS+1:0]    r_phase;
    logic [PW-1:0]                 r_acc;
    logic [CW-1:0]                 r_cnt;

    logic [PW-1:0]        n_acc;
    logic                 emit;
    logic                 more;
    logic                 last;
    logic [4*AW-1:0]      coef_l;
    logic [4*AW-1:0]      coef_r;

    // Doubled Hermite coefficients {k3,k2,k1,k0} of one channel, k0 lowest
    function automatic logic [4*AW-1:0] coefs(input logic signed [SAMPLE_BITS-1:0] a,
                                               input logic signed [SAMPLE_BITS-1:0] b,
                                               input logic signed [SAMPLE_BITS-1:0] c,
                                               input logic signed [SAMPLE_BITS-1:0] d);
        logic signed [AW-1:0] ea, eb, ec, ed, k3, k2, k1, k0, bc;
        ea = AW'(a);
        eb = AW'(b);
        ec = AW'(c);
        ed = AW'(d);
        bc = eb - ec;
        k3 = (ed - ea) + bc + (bc <<< 1);
        k2 = (ea <<< 1) - (eb <<< 2) - eb + (ec <<< 2) - ed;
        k1 = ec - ea;
        k0 = eb <<< 1;
        return {k3, k2, k1, k0};
    endfunction

    assign coef_l = coefs(r_hl[0], r_hl[1], r_hl[2], r_hl[3]);
    assign coef_r = coefs(r_hr[0], r_hr[1], r_hr[2], r_hr[3]);

    // one output per cycle while phase < 1, under the cap and while the job queue is not full
    assign more   = (r_acc < PH_ONE) && (r_cnt < CW'(MAX_OUTPUTS_PER_INPUT));
    assign emit   = (r_state == F_GEN) && more && !i_q_status.full;
    assign n_acc  = r_acc + PW'(i_step);
    assign last   = (n_acc >= PH_ONE) || (r_cnt == CW'(MAX_OUTPUTS_PER_INPUT - 1));

    assign o_ready = (r_state == F_IDLE);
    assign o_push  = emit;
    assign o_job   = {last, r_acc[PHASE_FRAC_BITS-1:0], coef_r, coef_l};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_phase <= '0;
            r_acc   <= '0;
            r_cnt   <= '0;
            for (int i = 0; i < 4; i++) begin
                r_hl[i] <= '0;
                r_hr[i] <= '0;
            end
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        for (int i = 0; i < 3; i++) begin
                            r_hl[i] <= r_hl[i+1];
                            r_hr[i] <= r_hr[i+1];
                        end
                        r_hl[3] <= i_left;
                        r_hr[3] <= i_right;
                        r_acc   <= PW'(r_phase);
                        r_cnt   <= '0;
                        r_state <= F_GEN;
                    end
                end
                F_GEN: begin
                    if (!more) begin
                        // wrap phase by one, or restart at zero when the cap cut it short
                        if (r_acc >= PH_ONE) begin
                            r_phase <= (PHASE_FRAC_BITS+2)'(r_acc - PH_ONE);
                        end else begin
                            r_phase <= '0;
                        end
                        r_state <= F_IDLE;
                    end else if (emit) begin
                        r_acc <= n_acc;
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

// ----- design/hsr_back.sv -----
// Back end: three-step Horner evaluation per channel, rounding, saturation and output register.
module hsr_back #(
    parameter int SAMPLE_BITS     = 24,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hsr_pkg::t_q_status          i_q_status,
    input  logic [8*(SAMPLE_BITS+hsr_pkg::ACC_GUARD_BITS)+PHASE_FRAC_BITS:0] i_job,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [SAMPLE_BITS-1:0]      o_left,
    output logic [SAMPLE_BITS-1:0]      o_right,
    output logic                        o_last
);

    localparam int AW  = SAMPLE_BITS + hsr_pkg::ACC_GUARD_BITS;
    localparam int PF  = PHASE_FRAC_BITS;
    localparam int MW  = AW + PF + 1;
    localparam logic signed [AW-1:0] SMAX = {{(AW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [AW-1:0] SMIN = ~SMAX;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_ADD,
        B_OUT
    } t_bstate;

    t_bstate              r_state;
    logic [1:0]           r_step;
    logic [8*AW-1:0]      r_coef;
    logic [PF-1:0]        r_f;
    logic                 r_last;
    logic signed [AW-1:0] r_acc_l;
    logic signed [AW-1:0] r_acc_r;
    logic signed [MW-1:0] r_prod_l;
    logic signed [MW-1:0] r_prod_r;
    logic                 r_ovalid;
    logic [SAMPLE_BITS-1:0] r_oleft;
    logic [SAMPLE_BITS-1:0] r_oright;
    logic                 r_olast;

    logic signed [AW-1:0] k_l;
    logic signed [AW-1:0] k_r;
    logic signed [MW-1:0] sh_l;
    logic signed [MW-1:0] sh_r;
    logic [SAMPLE_BITS-1:0] res_l;
    logic [SAMPLE_BITS-1:0] res_r;
    logic                 out_free;

    // Round half up by one bit, then clamp to the sample range
    function automatic logic [SAMPLE_BITS-1:0] finish(input logic signed [AW-1:0] t);
        logic signed [AW-1:0] h;
        h = (t + AW'(1)) >>> 1;
        if (h > SMAX) begin
            h = SMAX;
        end else if (h < SMIN) begin
            h = SMIN;
        end
        return h[SAMPLE_BITS-1:0];
    endfunction

    // coefficient added after each product: k2, k1, k0
    always_comb begin
        case (r_step)
            2'd0:    begin k_l = r_coef[2*AW +: AW]; k_r = r_coef[6*AW +: AW]; end
            2'd1:    begin k_l = r_coef[1*AW +: AW]; k_r = r_coef[5*AW +: AW]; end
            default: begin k_l = r_coef[0 +: AW];    k_r = r_coef[4*AW +: AW]; end
        endcase
    end

    assign sh_l     = r_prod_l >>> PF;
    assign sh_r     = r_prod_r >>> PF;
    assign res_l    = finish(r_acc_l);
    assign res_r    = finish(r_acc_r);
    assign out_free = !r_ovalid || i_ready;
    assign o_pop    = (r_state == B_IDLE) && !i_q_status.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // drop the output beat once taken, unless a new one is loaded now
            if (r_ovalid && i_ready && (r_state != B_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_status.empty) begin
                        r_coef  <= i_job[8*AW-1:0];
                        r_f     <= i_job[8*AW +: PF];
                        r_last  <= i_job[8*AW+PF];
                        r_acc_l <= i_job[3*AW +: AW];
                        r_acc_r <= i_job[7*AW +: AW];
                        r_step  <= '0;
                        r_state <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_prod_l <= MW'(r_acc_l) * MW'($signed({1'b0, r_f}));
                    r_prod_r <= MW'(r_acc_r) * MW'($signed({1'b0, r_f}));
                    r_state  <= B_ADD;
                end
                B_ADD: begin
                    r_acc_l <= sh_l[AW-1:0] + k_l;
                    r_acc_r <= sh_r[AW-1:0] + k_r;
                    if (r_step == 2'd2) begin
                        r_state <= B_OUT;
                    end else begin
                        r_step  <= r_step + 2'd1;
                        r_state <= B_MUL;
                    end
                end
                B_OUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_oleft  <= res_l;
                        r_oright <= res_r;
                        r_olast  <= r_last;
                        r_state  <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_left  = r_oleft;
    assign o_right = r_oright;
    assign o_last  = r_olast;

endmodule

// ----- design/hermite_stereo_resampler.sv -----
// Top level of the stereo 4-point cubic Hermite sample-rate converter.
//
// Slave stream (i_s_*): one beat carries a left/right input sample pair.
// Master stream (o_m_*): zero to MAX_OUTPUTS_PER_INPUT beats per input beat,
// each an interpolated, saturated left/right pair; tlast marks the final
// beat caused by one input beat. Config channel (i_cfg_*): step ratio in
// unsigned Q2.PHASE_FRAC_BITS, to be written only while the block is idle (the block does not enforce this).
// Each result passes the front end, the job queue and the back end, where
// it takes three Horner multiply/add steps on one multiplier per channel,
// plus load and output; the back end finishes one result before it pops
// the next job, and a beat with no result stays in the front end. The
// front end takes a new input once it has queued all jobs of the previous
// beat.
// Reset clears history, phase and queue and loads a step ratio of 1.0.
// A stalled receiver holds the output register; the job queue then fills
// and the front end, and with it i_s_tready, waits.
module hermite_stereo_resampler #(
    parameter int SAMPLE_BITS           = 24,
    parameter int PHASE_FRAC_BITS       = 16,
    parameter int MAX_OUTPUTS_PER_INPUT = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // config write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [PHASE_FRAC_BITS+1:0]   i_cfg_data,
    // input stream
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] i_s_tdata, // left_sample, right_sample
    // output stream
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] o_m_tdata, // left_out, right_out
    output logic                         o_m_tlast
);

    localparam int TW    = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int AW    = SAMPLE_BITS + hsr_pkg::ACC_GUARD_BITS;
    localparam int JW    = 8*AW + PHASE_FRAC_BITS + 1;
    localparam int STW   = PHASE_FRAC_BITS + 2;

    logic [STW-1:0]          r_step;
    logic                    q_push;
    logic                    q_pop;
    logic [JW-1:0]           job_in;
    logic [JW-1:0]           job_out;
    hsr_pkg::t_q_status      q_status;
    logic [SAMPLE_BITS-1:0]  out_l;
    logic [SAMPLE_BITS-1:0]  out_r;

    // step ratio register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STW'(1) << PHASE_FRAC_BITS;
        end else if (i_cfg_valid) begin
            r_step <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    hsr_front #(
        .SAMPLE_BITS           (SAMPLE_BITS),
        .PHASE_FRAC_BITS       (PHASE_FRAC_BITS),
        .MAX_OUTPUTS_PER_INPUT (MAX_OUTPUTS_PER_INPUT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_left     (i_s_tdata[SAMPLE_BITS-1:0]),
        .i_right    (i_s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .i_step     (r_step),
        .i_q_status (q_status),
        .o_push     (q_push),
        .o_job      (job_in)
    );

    hsr_job_queue #(
        .WIDTH (JW)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (job_in),
        .i_pop    (q_pop),
        .o_data   (job_out),
        .o_status (q_status)
    );

    hsr_back #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_job      (job_out),
        .o_pop      (q_pop),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_left     (out_l),
        .o_right    (out_r),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = TW'({out_r, out_l});

    // queue never overflows or underflows
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full) else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty) else $error("job popped from empty queue");

    // front end is busy in the cycle after taking a beat
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready) else $error("front end took two beats");

endmodule
